/* rtl/nearest_palette_color_match_macros.svh */
// assertion helpers used by the checker file
`ifndef NEAREST_PALETTE_COLOR_MATCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MATCH_MACROS_SVH

// same-cycle implication, muted during reset
`define NPCM_ASSERT_NOW(label, clk, rst, cond, expect_expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_expr)) \
    else $error("npcm assertion failed");

// next-cycle implication, muted during reset
`define NPCM_ASSERT_NEXT(label, clk, rst, cond, expect_expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_expr)) \
    else $error("npcm assertion failed");

`endif

/* rtl/npcm_pkg.sv */
`default_nettype none

package npcm_pkg;

  localparam int CH_W   = 8;
  localparam int IDX_W  = 8;
  localparam int DIST_W = 10;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  // travels alongside each palette entry read during a scan
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] index;
  } scan_tag_t;

endpackage

`default_nettype wire

/* rtl/npcm_if.sv */
`default_nettype none

interface npcm_in_if;
  import npcm_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0] entry_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  modport source (output valid, action, entry_index, red, green, blue, input ready);
  modport sink (input valid, action, entry_index, red, green, blue, output ready);
endinterface

interface npcm_out_if;
  import npcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  match_index;
  logic [DIST_W-1:0] match_distance;

  modport source (output valid, match_index, match_distance, input ready);
  modport sink (input valid, match_index, match_distance, output ready);
endinterface

`default_nettype wire

/* rtl/npcm_ram.sv */
`default_nettype none

module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/npcm_best.sv */
`default_nettype none

module npcm_best
  import npcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scan_tag_t         tag,
  input  wire color_t            entry,
  input  wire color_t            query,
  output logic                   done,
  output logic [IDX_W-1:0]       best_index,
  output logic [DIST_W-1:0]      best_dist
);

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  scan_tag_t         a_tag;
  logic [DIST_W-1:0] a_dist;
  logic [DIST_W-1:0] entry_dist;

  assign entry_dist = DIST_W'(abs_diff(entry.red, query.red))
                    + DIST_W'(abs_diff(entry.green, query.green))
                    + DIST_W'(abs_diff(entry.blue, query.blue));

  // stage a: distance of the entry just read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else begin
      a_tag <= tag;
    end
    a_dist <= entry_dist;
  end

  // stage b: running minimum, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_tag.valid && a_tag.last;
    end
    if (a_tag.valid && (a_tag.first || a_dist < best_dist)) begin
      best_dist  <= a_dist;
      best_index <= a_tag.index;
    end
  end

endmodule

`default_nettype wire

/* rtl/nearest_palette_color_match.sv */
`default_nettype none

// Nearest palette color match. A write item (action 0) stores one red/green/blue entry
// in the palette in the cycle it is transferred; an entry_index at or beyond
// PALETTE_ENTRIES is dropped. A query item (action 1) scans every palette entry and
// returns the index with the smallest sum of absolute channel differences, lowest index
// on a tie, plus that distance. The scan reads one entry per cycle from the palette RAM,
// and no new item is taken until the result sits in the output register. Palette
// entries never written since reset read as black, tracked by per-entry valid bits
// that reset clears at once, so the block is usable right after reset.
module nearest_palette_color_match
  import npcm_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input wire logic clk,
  input wire logic rst,
  npcm_in_if.sink  req,
  npcm_out_if.source rsp
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [AW-1:0]             cnt;
  logic                      cnt_last;
  logic [PALETTE_ENTRIES-1:0] valid;
  logic                      vld_q;
  scan_tag_t                 tag_q;
  color_t                    query;
  logic [3*CH_W-1:0]         rdata;
  color_t                    entry;
  logic                      in_fire;
  logic                      in_range;
  logic                      wr_en;
  logic                      push_fire;
  logic                      done;
  logic [IDX_W-1:0]          best_index;
  logic [DIST_W-1:0]         best_dist;
  logic                      out_valid;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign in_range  = {1'b0, req.entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign wr_en     = in_fire && (req.action == ACT_WRITE) && in_range;
  assign cnt_last  = (cnt == AW'(PALETTE_ENTRIES - 1));
  assign push_fire = (state == S_PUSH) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && req.action == ACT_QUERY) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      valid <= '0;
      tag_q <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        cnt <= '0;
      end else if (state == S_SCAN) begin
        cnt <= cnt + AW'(1);
      end
      if (wr_en) begin
        valid[req.entry_index[AW-1:0]] <= 1'b1;
      end
      tag_q.valid <= (state == S_SCAN);
      tag_q.first <= (cnt == '0);
      tag_q.last  <= cnt_last;
      tag_q.index <= IDX_W'(cnt);
    end
    vld_q <= valid[cnt];
    if (in_fire) begin
      query.red   <= req.red;
      query.green <= req.green;
      query.blue  <= req.blue;
    end
  end

  npcm_ram #(
    .WIDTH (3 * CH_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (req.entry_index[AW-1:0]),
    .wdata ({req.red, req.green, req.blue}),
    .re    (state == S_SCAN),
    .raddr (cnt),
    .rdata (rdata)
  );

  // never-written entries read as black
  assign entry = vld_q ? color_t'(rdata) : '0;

  npcm_best u_best (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag_q),
    .entry      (entry),
    .query      (query),
    .done       (done),
    .best_index (best_index),
    .best_dist  (best_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (push_fire) begin
      rsp.match_index    <= best_index;
      rsp.match_distance <= best_dist;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

/* rtl/npcm_checker.sv */
`default_nettype none

`include "nearest_palette_color_match_macros.svh"

module npcm_checker
  import npcm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_action,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [IDX_W-1:0]  out_index,
  input wire logic [DIST_W-1:0] out_distance
);

  // a pending result is neither dropped nor altered
  `NPCM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `NPCM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_index) && $stable(out_distance))
  // a write transfer never produces a result
  `NPCM_ASSERT_NEXT(a_write_silent, clk, rst, in_valid && in_ready && in_action == ACT_WRITE, !$rose(out_valid))
  // a query occupies the block until its result is out
  `NPCM_ASSERT_NEXT(a_query_busy, clk, rst, in_valid && in_ready && in_action == ACT_QUERY, !in_ready)
  `NPCM_ASSERT_NOW(a_dist_range, clk, rst, out_valid, out_distance <= DIST_W'(765))

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .in_action    (req.action),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .out_index    (rsp.match_index),
  .out_distance (rsp.match_distance)
);

`default_nettype wire

/* tb/nearest_palette_color_match_test.sv */
`default_nettype none

module nearest_palette_color_match_test;
  import npcm_pkg::*;

  localparam int PALETTE_SIZE = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1725;
  localparam int LONG_HOLD_CYCLES = 2500;
  localparam int DRAIN_CYCLES = PALETTE_SIZE + 40;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } match_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic clk;
  logic rst;

  npcm_in_if  in_bus();
  npcm_out_if out_bus();

  nearest_palette_color_match #(
    .PALETTE_ENTRIES(PALETTE_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(in_bus.sink),
    .rsp(out_bus.source)
  );

  color_t palette_model [PALETTE_SIZE];
  match_t expected_matches[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned write_count;
  int unsigned query_count;
  int unsigned checked_count;
  int unsigned tie_count;
  int unsigned longest_hold;
  int unsigned hold_request;
  int unsigned burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_matches.size());
      $display("simulation failed");
      $finish;
    end
  end

  // nearest entry by manhattan distance, first index kept on a tie
  function automatic match_t predict_nearest(color_t c, output bit tied);
    match_t best;
    int d;
    int best_dist;
    best = '0;
    best_dist = 0;
    tied = 1'b0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      d = ((palette_model[i].red > c.red) ? palette_model[i].red - c.red
                                          : c.red - palette_model[i].red)
        + ((palette_model[i].green > c.green) ? palette_model[i].green - c.green
                                              : c.green - palette_model[i].green)
        + ((palette_model[i].blue > c.blue) ? palette_model[i].blue - c.blue
                                            : c.blue - palette_model[i].blue);
      if (i == 0 || d < best_dist) begin
        best_dist = d;
        best.index = IDX_W'(i);
        tied = 1'b0;
      end else if (d == best_dist) begin
        tied = 1'b1;
      end
    end
    best.distance = DIST_W'(best_dist);
    return best;
  endfunction

  function automatic color_t random_color();
    color_t c;
    c.red = CH_W'($urandom);
    c.green = CH_W'($urandom);
    c.blue = CH_W'($urandom);
    return c;
  endfunction

  function automatic color_t corner_color();
    color_t c;
    c.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
    c.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
    c.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return c;
  endfunction

  function automatic logic [CH_W-1:0] nudge(logic [CH_W-1:0] v);
    int n;
    n = int'(v) + $urandom_range(0, 8) - 4;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return CH_W'(n);
  endfunction

  // offers one item in bursts with random gaps, updates the palette copy on transfer
  task automatic send_item(logic action, logic [IDX_W-1:0] entry, color_t c);
    int gap;
    bit tied;
    match_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        @(negedge clk);
        in_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.action = action;
    in_bus.entry_index = entry;
    in_bus.red = c.red;
    in_bus.green = c.green;
    in_bus.blue = c.blue;
    do @(posedge clk); while (!in_bus.ready);
    if (action == ACT_WRITE) begin
      write_count++;
      if (int'(entry) < PALETTE_SIZE) palette_model[entry] = c;
    end else begin
      query_count++;
      want = predict_nearest(c, tied);
      if (tied) tie_count++;
      expected_matches.push_back(want);
    end
  endtask

  task automatic send_query(color_t c);
    send_item(ACT_QUERY, IDX_W'($urandom), c);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  // receiver: ready pattern changes from stretch to stretch, long hold on request
  initial begin
    rx_mode_e mode;
    int unsigned phase_left;
    int unsigned stall_left;
    int unsigned hold_left;
    mode = RX_STEADY;
    phase_left = 0;
    stall_left = 0;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
        if (hold_left > longest_hold) longest_hold = hold_left;
      end
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          phase_left = $urandom_range(300, 3000);
        end
        phase_left--;
        case (mode)
          RX_STEADY: out_bus.ready = 1'b1;
          RX_COIN: out_bus.ready = 1'($urandom_range(0, 1));
          RX_PERIODIC: out_bus.ready = (cycle_count % 11) > 3;
          default: begin
            if (stall_left > 0) begin
              out_bus.ready = 1'b0;
              stall_left--;
            end else if ($urandom_range(0, 20) == 0) begin
              stall_left = $urandom_range(5, 60);
              out_bus.ready = 1'b0;
            end else begin
              out_bus.ready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    match_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_matches.size() == 0) begin
        $error("result with nothing pending: match_index %0d match_distance %0d",
               out_bus.match_index, out_bus.match_distance);
        error_count++;
      end else begin
        want = expected_matches.pop_front();
        checked_count++;
        if (out_bus.match_index !== want.index) begin
          $error("match_index expected %0d actual %0d", want.index, out_bus.match_index);
          error_count++;
        end
        if (out_bus.match_distance !== want.distance) begin
          $error("match_distance expected %0d actual %0d", want.distance,
                 out_bus.match_distance);
          error_count++;
        end
      end
    end
  end

  // freshly reset palette is all black
  task automatic test_query_after_reset();
    send_query('{8'h00, 8'h00, 8'h00});
    send_query('{8'hff, 8'hff, 8'hff});
    wait_for_drain();
  endtask

  task automatic test_channel_extremes();
    send_item(ACT_WRITE, 8'hff, '{8'hff, 8'hff, 8'hff});
    send_item(ACT_WRITE, 8'h01, '{8'hff, 8'h00, 8'h00});
    send_item(ACT_WRITE, 8'h02, '{8'h00, 8'hff, 8'h00});
    send_item(ACT_WRITE, 8'h03, '{8'h00, 8'h00, 8'hff});
    send_query('{8'hff, 8'hff, 8'hff});
    send_query('{8'hc8, 8'h0a, 8'h0a});
    send_query('{8'h00, 8'hff, 8'hff});
    send_query('{8'h80, 8'h80, 8'h80});
    send_query('{8'hff, 8'h00, 8'hff});
    wait_for_drain();
  endtask

  task automatic test_tie_lowest_index();
    send_item(ACT_WRITE, 8'd200, '{8'd77, 8'd150, 8'd33});
    send_item(ACT_WRITE, 8'd100, '{8'd77, 8'd150, 8'd33});
    send_item(ACT_WRITE, 8'd40, '{8'd77, 8'd150, 8'd33});
    send_query('{8'd77, 8'd150, 8'd33});
    send_query('{8'd78, 8'd149, 8'd33});
    send_item(ACT_WRITE, 8'd40, '{8'd0, 8'd0, 8'd0});
    send_query('{8'd77, 8'd150, 8'd33});
    send_item(ACT_WRITE, 8'd0, '{8'd77, 8'd150, 8'd33});
    send_query('{8'd77, 8'd150, 8'd33});
    wait_for_drain();
  endtask

  // receiver holds off while queries keep coming, so the input must stall
  task automatic test_output_hold();
    hold_request = LONG_HOLD_CYCLES;
    repeat (4) send_query(random_color());
    wait_for_drain();
  endtask

  task automatic test_random_mix();
    int roll;
    color_t c;
    logic [IDX_W-1:0] src;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      src = IDX_W'($urandom);
      if (roll < 33) begin
        send_item(ACT_WRITE, IDX_W'($urandom), random_color());
      end else if (roll < 43) begin
        // duplicate an existing color elsewhere to set up ties
        send_item(ACT_WRITE, IDX_W'($urandom), palette_model[src]);
      end else if (roll < 48) begin
        send_item(ACT_WRITE, IDX_W'($urandom), corner_color());
      end else if (roll < 75) begin
        c = palette_model[src];
        if ($urandom_range(0, 3) != 0) begin
          c.red = nudge(c.red);
          c.green = nudge(c.green);
          c.blue = nudge(c.blue);
        end
        send_query(c);
      end else if (roll < 95) begin
        send_query(random_color());
      end else begin
        send_query(corner_color());
      end
    end
    wait_for_drain();
  endtask

  initial begin
    rst = 1'b1;
    cycle_count = 0;
    error_count = 0;
    write_count = 0;
    query_count = 0;
    checked_count = 0;
    tie_count = 0;
    longest_hold = 0;
    hold_request = 0;
    burst_left = 0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_WRITE;
    in_bus.entry_index = '0;
    in_bus.red = '0;
    in_bus.green = '0;
    in_bus.blue = '0;
    for (int i = 0; i < PALETTE_SIZE; i++) palette_model[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_query_after_reset();
    test_channel_extremes();
    test_tie_lowest_index();
    test_output_hold();
    test_random_mix();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d palette writes and %0d queries sent, %0d results checked", write_count,
             query_count, checked_count);
    $display("%0d queries hit a distance tie, longest output hold-off %0d cycles",
             tie_count, longest_hold);
    if (error_count == 0 && expected_matches.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
